>>> hdl/pi_aqm_drop_controller_unit_macros.svh
// assertion macros for the pi aqm drop controller checker
// no dependencies; included by the checker file only
`ifndef PI_AQM_DROP_CONTROLLER_UNIT_MACROS_SVH
`define PI_AQM_DROP_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PIAQM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("piaqm assertion failed");

// next-cycle implication, disabled during reset
`define PIAQM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("piaqm assertion failed");

// next-cycle implication, always active
`define PIAQM_ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("piaqm assertion failed");

`endif

>>> hdl/piaqm_pkg.sv
// shared types and constants for the pi aqm drop controller
// no dependencies
package piaqm_pkg;

    localparam int unsigned PROB_W  = 64;
    localparam int unsigned GAIN_W  = 60;
    localparam int unsigned CFG_W   = 60;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned DIN_W   = 88;
    localparam int unsigned DOUT_W  = 88;
    localparam int unsigned USER_W  = 2;

    typedef enum logic [1:0] {
        ACT_ENQ  = 2'd0,
        ACT_DEQ  = 2'd1,
        ACT_TICK = 2'd2,
        ACT_NOP  = 2'd3
    } t_action;

    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_MARK      = 3'd1;
    localparam logic [2:0] VERDICT_EARLY     = 3'd2;
    localparam logic [2:0] VERDICT_OVERLIMIT = 3'd3;
    localparam logic [2:0] VERDICT_NONE      = 3'd4;

    localparam logic [CIDX_W-1:0] CFG_TARGET = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_LIMIT  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_ALPHA  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_BETA   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_ECN    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_BYTE   = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_MTU    = 3'd6;

    localparam logic [15:0]       RST_TARGET = 16'd50;
    localparam logic [15:0]       RST_LIMIT  = 16'd1000;
    localparam logic [GAIN_W-1:0] RST_ALPHA  = 60'd18220000000000;
    localparam logic [GAIN_W-1:0] RST_BETA   = 60'd18160000000000;
    localparam logic [15:0]       RST_MTU    = 16'd1514;

    typedef enum logic [2:0] {
        MS_A_LO = 3'd0,
        MS_A_HI = 3'd1,
        MS_B_LO = 3'd2,
        MS_B_HI = 3'd3,
        MS_Q_LO = 3'd4,
        MS_Q_HI = 3'd5
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     gain_clr;
        logic     div_start;
        logic     div_step;
        logic     div_last;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    use_scale;
        logic    q_stale;
        logic    out_free;
    } t_dp_sts;

endpackage

>>> hdl/piaqm_dp.sv
// datapath: config registers, queue state, shared 32x17 multiplier, mtu divider
// depends on piaqm_pkg
module piaqm_dp
    import piaqm_pkg::*;
#(
    parameter int unsigned MAX_QUEUE_PACKETS = 65535
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CIDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic [USER_W-1:0]   i_in_user,
    input  logic [DIN_W-1:0]    i_in_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [DOUT_W-1:0]   o_out_data,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts
);

    localparam logic [15:0] MAX_Q = 16'(MAX_QUEUE_PACKETS);

    logic [15:0]       r_target, r_limit, r_mtu;
    logic [GAIN_W-1:0] r_alpha, r_beta;
    logic              r_ecn, r_byte;

    logic [PROB_W-1:0] r_prob;
    logic [15:0]       r_qlen, r_qold;

    t_action           r_act;
    logic [15:0]       r_size;
    logic              r_cap;
    logic [PROB_W-1:0] r_rnd;

    logic [PROB_W-1:0] r_ga, r_gb, r_acc;
    logic [PROB_W-1:0] r_divq;
    logic [16:0]       r_rem;
    logic              r_stale;

    logic signed [49:0] r_prod;
    t_mul_sel           r_prod_sel;
    logic               r_prod_vld;

    logic               r_out_vld;
    logic [DOUT_W-1:0]  r_out;

    logic signed [16:0] err_now, err_old, size_s, mul_y;
    logic [31:0]        mul_x;
    logic signed [49:0] mul_p;
    logic [PROB_W-1:0]  term;
    logic [16:0]        div_t;
    logic               div_ge;
    logic [PROB_W:0]    sum65;
    logic [PROB_W-1:0]  after, p_use;
    logic               positive, overlimit, hit;
    logic [2:0]         verdict;
    logic               empty;
    logic [15:0]        qlen_n;
    logic [PROB_W-1:0]  prob_n;
    logic               use_scale;

    assign err_now = $signed({1'b0, r_qlen}) - $signed({1'b0, r_target});
    assign err_old = $signed({1'b0, r_qold}) - $signed({1'b0, r_target});
    assign size_s  = $signed({1'b0, r_size});
    assign use_scale = r_byte && (r_mtu != 16'd0) && (r_size <= r_mtu);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_A_LO: begin mul_x = r_ga[31:0];    mul_y = err_now; end
            MS_A_HI: begin mul_x = r_ga[63:32];   mul_y = err_now; end
            MS_B_LO: begin mul_x = r_gb[31:0];    mul_y = err_old; end
            MS_B_HI: begin mul_x = r_gb[63:32];   mul_y = err_old; end
            MS_Q_LO: begin mul_x = r_divq[31:0];  mul_y = size_s;  end
            default: begin mul_x = r_divq[63:32]; mul_y = size_s;  end
        endcase
    end
    assign mul_p = $signed({1'b0, mul_x}) * mul_y;

    always_comb begin
        term = {{(PROB_W-50){r_prod[49]}}, r_prod};
        if (r_prod_sel == MS_A_HI || r_prod_sel == MS_B_HI || r_prod_sel == MS_Q_HI) begin
            term = {term[31:0], 32'd0};
        end
    end

    assign div_t  = {r_rem[15:0], r_divq[63]};
    assign div_ge = div_t >= {1'b0, r_mtu};

    // commit-time results
    always_comb begin
        sum65    = {1'b0, r_prob} + {1'b0, r_acc};
        positive = (r_acc != '0) && !r_acc[63];
        after    = sum65[PROB_W-1:0];
        if (positive && sum65[PROB_W]) begin
            after = '1;
        end else if (!positive && (after > r_prob)) begin
            after = '0;
        end
        p_use     = use_scale ? r_acc : r_prob;
        overlimit = (r_qlen >= r_limit) || (r_qlen >= MAX_Q);
        hit       = r_rnd < p_use;
        verdict   = VERDICT_NONE;
        empty     = 1'b0;
        qlen_n    = r_qlen;
        prob_n    = r_prob;
        case (r_act)
            ACT_ENQ: begin
                if (overlimit) begin
                    verdict = VERDICT_OVERLIMIT;
                end else if (hit && !(r_ecn && r_cap)) begin
                    verdict = VERDICT_EARLY;
                end else begin
                    verdict = hit ? VERDICT_MARK : VERDICT_ACCEPT;
                    qlen_n  = r_qlen + 16'd1;
                end
            end
            ACT_DEQ: begin
                if (r_qlen == 16'd0) begin
                    empty = 1'b1;
                end else begin
                    qlen_n = r_qlen - 16'd1;
                end
            end
            ACT_TICK: prob_n = after;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= RST_TARGET;
            r_limit    <= RST_LIMIT;
            r_alpha    <= RST_ALPHA;
            r_beta     <= RST_BETA;
            r_ecn      <= 1'b0;
            r_byte     <= 1'b0;
            r_mtu      <= RST_MTU;
            r_prob     <= '0;
            r_qlen     <= '0;
            r_qold     <= '0;
            r_divq     <= '0;
            r_stale    <= 1'b0;
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET: r_target <= i_cfg_data[15:0];
                    CFG_LIMIT:  r_limit  <= i_cfg_data[15:0];
                    CFG_ALPHA:  r_alpha  <= i_cfg_data[GAIN_W-1:0];
                    CFG_BETA:   r_beta   <= i_cfg_data[GAIN_W-1:0];
                    CFG_ECN:    r_ecn    <= i_cfg_data[0];
                    CFG_BYTE:   r_byte   <= i_cfg_data[0];
                    CFG_MTU: begin
                        r_mtu   <= i_cfg_data[15:0];
                        r_stale <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.div_start) begin
                r_divq <= r_prob;
            end else if (i_cmd.div_step) begin
                r_divq <= {r_divq[62:0], div_ge};
            end
            if (i_cmd.div_last) begin
                r_stale <= 1'b0;
            end
            r_prod_vld <= i_cmd.mul_en;
            if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
                r_prob    <= prob_n;
                r_qlen    <= qlen_n;
                if (r_act == ACT_TICK) begin
                    r_qold  <= r_qlen;
                    r_stale <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= t_action'(i_in_user);
            r_size <= i_in_data[15:0];
            r_cap  <= i_in_data[16];
            r_rnd  <= i_in_data[80:17];
        end
        if (i_cmd.gain_clr) begin
            // times 18 = times 16 plus times 2
            r_ga  <= {r_alpha, 4'd0} + {3'd0, r_alpha, 1'b0};
            r_gb  <= {r_beta, 4'd0} + {3'd0, r_beta, 1'b0};
            r_acc <= '0;
        end else if (r_prod_vld) begin
            if (r_prod_sel == MS_B_LO || r_prod_sel == MS_B_HI) begin
                r_acc <= r_acc - term;
            end else begin
                r_acc <= r_acc + term;
            end
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? (div_t - {1'b0, r_mtu}) : div_t;
        end
        if (i_cmd.mul_en) begin
            r_prod     <= mul_p;
            r_prod_sel <= i_cmd.mul_sel;
        end
        if (i_cmd.commit) begin
            r_out <= {4'd0, qlen_n, prob_n, empty, verdict};
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_out_data      = r_out;
    assign o_sts.action    = r_act;
    assign o_sts.use_scale = use_scale;
    assign o_sts.q_stale   = r_stale;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

endmodule

>>> hdl/piaqm_ctrl.sv
// controller state machine: sequences divider, multiplier passes and commit
// depends on piaqm_pkg
module piaqm_ctrl
    import piaqm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_DIV, S_TMUL0, S_TMUL1, S_TMUL2, S_TMUL3,
        S_TDRAIN, S_BMUL0, S_BMUL1, S_BDRAIN, S_FINAL
    } t_state;

    t_state     r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.gain_clr = 1'b1;
                if (i_sts.action == ACT_TICK) begin
                    n_state = S_TMUL0;
                end else if (i_sts.action == ACT_ENQ && i_sts.use_scale) begin
                    o_cmd.div_start = i_sts.q_stale;
                    n_state = i_sts.q_stale ? S_DIV : S_BMUL0;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_last = (r_cnt == '1);
                n_cnt          = r_cnt + 6'd1;
                if (r_cnt == '1) begin
                    n_state = S_BMUL0;
                end
            end
            S_TMUL0: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_A_LO; n_state = S_TMUL1; end
            S_TMUL1: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_A_HI; n_state = S_TMUL2; end
            S_TMUL2: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_B_LO; n_state = S_TMUL3; end
            S_TMUL3: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_B_HI; n_state = S_TDRAIN; end
            S_TDRAIN: n_state = S_FINAL;
            S_BMUL0: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_Q_LO; n_state = S_BMUL1; end
            S_BMUL1: begin o_cmd.mul_en = 1'b1; o_cmd.mul_sel = MS_Q_HI; n_state = S_BDRAIN; end
            S_BDRAIN: n_state = S_FINAL;
            S_FINAL: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

>>> hdl/pi_aqm_drop_controller_unit.sv
// path from input beat to result beat: load, dispatch and commit for enqueue, dequeue and no-op;
// an update tick adds the alpha and beta multiplier passes and a drain, a byte-mode enqueue the quotient
// passes and a drain, plus the 64-step divider first when the quotient is stale (after each tick or mtu write)
// one item in flight; a new beat is taken once the result sits in the output register
// synchronous active-low reset: config to defaults, probability and counts to zero
module pi_aqm_drop_controller_unit
    import piaqm_pkg::*;
#(
    parameter int unsigned MAX_QUEUE_PACKETS = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CIDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // pkt_len[15:0], ecn_capable[16], random_word[80:17], zero pad
    input  logic [DIN_W-1:0]   s_axis_tdata,
    // action[1:0]
    input  logic [USER_W-1:0]  s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // verdict[2:0], dequeue_empty[3], drop_probability[67:4], queue_count[83:68], zero pad
    output logic [DOUT_W-1:0]  m_axis_tdata
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    piaqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    piaqm_dp #(
        .MAX_QUEUE_PACKETS (MAX_QUEUE_PACKETS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> hdl/piaqm_checker.sv
// port-level checker for the pi aqm drop controller, bound to the top level
// depends on piaqm_pkg and the macros header
`include "pi_aqm_drop_controller_unit_macros.svh"

module piaqm_checker
    import piaqm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [DOUT_W-1:0]  m_axis_tdata
);

    `PIAQM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PIAQM_ASSERT_IMPLY(a_verdict_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= VERDICT_NONE)
    `PIAQM_ASSERT_IMPLY(a_empty_deq, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[83:68] == 16'd0 && m_axis_tdata[2:0] == VERDICT_NONE)
    `PIAQM_ASSERT_IMPLY(a_accept_count, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[2:0] == VERDICT_ACCEPT || m_axis_tdata[2:0] == VERDICT_MARK), m_axis_tdata[83:68] != 16'd0)
    `PIAQM_ASSERT_NEXT_RAW(a_reset_quiet, i_clk, !i_rst_n, !m_axis_tvalid)

endmodule

bind pi_aqm_drop_controller_unit piaqm_checker u_piaqm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> sim/tb.sv
// self-checking testbench for the pi aqm drop controller unit
// depends on piaqm_pkg and the rtl top; predicts every result beat in a scoreboard class
`timescale 1ns / 100ps

module tb;
    import piaqm_pkg::*;

    localparam int unsigned MAXQ      = 65535;
    localparam longint      CYC_LIMIT = 1500000;
    localparam logic [63:0] ALL_ONES  = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] GAIN_DIV  = 64'd1000000000000000000;
    // index past the last register, ignored by the block
    localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        empty;
        logic [63:0] prob;
        logic [15:0] count;
    } t_outcome;

    class drop_scoreboard;
        logic [15:0] target, limit, mtu;
        logic [59:0] alpha, beta;
        logic        ecn_on, byte_on;
        logic [63:0] prob;
        logic [15:0] qlen, qold;
        t_outcome    pending[$];
        int          errors;

        function new();
            target = RST_TARGET; limit = RST_LIMIT; mtu = RST_MTU;
            alpha = RST_ALPHA; beta = RST_BETA; ecn_on = 0; byte_on = 0;
            prob = '0; qlen = '0; qold = '0; errors = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_TARGET: target = v[15:0];
                CFG_LIMIT:  limit = v[15:0];
                CFG_ALPHA:  alpha = v;
                CFG_BETA:   beta = v;
                CFG_ECN:    ecn_on = v[0];
                CFG_BYTE:   byte_on = v[0];
                CFG_MTU:    mtu = v[15:0];
                default: ;
            endcase
        endfunction

        function void tick();
            logic [63:0] e_now, e_old, ga, gb, delta, sum;
            logic        up;
            e_now = {48'd0, qlen} - {48'd0, target};
            e_old = {48'd0, qold} - {48'd0, target};
            ga = {4'd0, alpha} * (ALL_ONES / GAIN_DIV);
            gb = {4'd0, beta} * (ALL_ONES / GAIN_DIV);
            delta = ga * e_now - gb * e_old;
            sum = prob + delta;
            up = (delta != 0) && !delta[63];
            if (up) begin
                if (sum < prob) sum = ALL_ONES;
            end else begin
                if (sum > prob) sum = '0;
            end
            prob = sum;
            qold = qlen;
        endfunction

        function void note_beat(t_action act, logic [15:0] size, logic cap, logic [63:0] rnd);
            t_outcome o;
            logic [63:0] p;
            o.verdict = VERDICT_NONE;
            o.empty = 0;
            case (act)
                ACT_ENQ: begin
                    p = prob;
                    if (qlen >= limit || qlen >= MAXQ) o.verdict = VERDICT_OVERLIMIT;
                    else begin
                        if (byte_on && mtu != 0 && size <= mtu)
                            p = {48'd0, size} * (prob / {48'd0, mtu});
                        if (rnd < p) begin
                            if (ecn_on && cap) begin
                                qlen++;
                                o.verdict = VERDICT_MARK;
                            end else o.verdict = VERDICT_EARLY;
                        end else begin
                            qlen++;
                            o.verdict = VERDICT_ACCEPT;
                        end
                    end
                end
                ACT_DEQ: begin
                    if (qlen == 0) o.empty = 1;
                    else qlen--;
                end
                ACT_TICK: tick();
                default: ;
            endcase
            o.prob = prob;
            o.count = qlen;
            pending.push_back(o);
        endfunction

        function void check_beat(logic [DOUT_W-1:0] d);
            t_outcome e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, d);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] !== e.verdict) begin
                $display("%0t: verdict exp %0d got %0d", $time, e.verdict, d[2:0]);
                errors++;
            end
            if (d[3] !== e.empty) begin
                $display("%0t: dequeue_empty exp %0d got %0d", $time, e.empty, d[3]);
                errors++;
            end
            if (d[67:4] !== e.prob) begin
                $display("%0t: probability exp %h got %h", $time, e.prob, d[67:4]);
                errors++;
            end
            if (d[83:68] !== e.count) begin
                $display("%0t: queue_count exp %0d got %0d", $time, e.count, d[83:68]);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 0, i_rst_n = 0;
    logic               i_cfg_we = 0;
    logic [CIDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 0, s_axis_tready;
    logic [DIN_W-1:0]   s_axis_tdata = '0;
    logic [USER_W-1:0]  s_axis_tuser = '0;
    logic               m_axis_tvalid, m_axis_tready = 0;
    logic [DOUT_W-1:0]  m_axis_tdata;

    drop_scoreboard sb;
    longint cycles = 0;
    bit     hold_off = 0;
    int     stall_mode = 0;

    pi_aqm_drop_controller_unit uut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("pi_aqm_drop_controller_unit regression: fail");
            $finish;
        end
    end

    // result side: checks accepted beats and stalls on its own pattern
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
        if (hold_off) m_axis_tready <= 0;
        else case (stall_mode)
            0: m_axis_tready <= 1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    task automatic write_cfg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, v);
    endtask

    // waits for all results, then lets the longest latency pass
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_beat(t_action act, logic [15:0] size, logic cap, logic [63:0] rnd);
        s_axis_tvalid <= 1;
        s_axis_tuser <= act;
        s_axis_tdata <= {7'd0, rnd, cap, size};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(act, size, cap, rnd);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // mostly enqueues with some dequeues, ticks and rare no-ops; bias sets fill vs drain
    task automatic random_run(int n, int enq_pct, int tick_pct);
        int burst, k, r;
        logic [63:0] rnd;
        t_action act;
        burst = $urandom_range(1, 12);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < enq_pct) act = ACT_ENQ;
            else if (r < enq_pct + tick_pct) act = ACT_TICK;
            else if (r < 98) act = ACT_DEQ;
            else act = ACT_NOP;
            rnd = rand64();
            if ($urandom_range(0, 3) == 0) rnd = rnd >> $urandom_range(1, 63);
            send_beat(act, $urandom_range(0, 3) == 0 ? 16'($urandom) :
                      16'($urandom_range(40, 1600)), 1'($urandom_range(0, 1)), rnd);
            if (--burst == 0) begin
                burst = $urandom_range(1, 12);
                if ($urandom_range(0, 2) != 0) pause_sender();
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, every action, empty dequeue, unused code
        send_beat(ACT_DEQ, 16'd0, 1'b0, '0);
        send_beat(ACT_NOP, 16'hffff, 1'b1, ALL_ONES);
        send_beat(ACT_ENQ, 16'hffff, 1'b1, ALL_ONES);
        send_beat(ACT_ENQ, 16'd0, 1'b0, '0);
        send_beat(ACT_TICK, 16'd0, 1'b0, '0);
        send_beat(ACT_DEQ, 16'd0, 1'b0, '0);
        s_axis_tvalid <= 0;
        drain();
        // huge gains: drive probability to a clamp
        write_cfg(CFG_ALPHA, 60'd1000000000000000000);
        write_cfg(CFG_BETA, 60'd0);
        write_cfg(CFG_TARGET, 60'd0);
        for (int k = 0; k < 4; k++) send_beat(ACT_ENQ, 16'd100, k[0], '0);
        send_beat(ACT_TICK, 16'd0, 1'b0, '0);
        send_beat(ACT_TICK, 16'd0, 1'b0, '0);
        send_beat(ACT_ENQ, 16'd100, 1'b0, ALL_ONES);
        send_beat(ACT_ENQ, 16'd100, 1'b1, 64'd5);
        s_axis_tvalid <= 0;
        drain();
        write_cfg(CFG_ECN, 60'd1);
        write_cfg(CFG_BYTE, 60'd1);
        write_cfg(CFG_MTU, 60'd0);
        send_beat(ACT_ENQ, 16'd100, 1'b1, 64'd5);
        s_axis_tvalid <= 0;
        drain();
        write_cfg(CFG_MTU, 60'd1);
        send_beat(ACT_ENQ, 16'd2, 1'b0, 64'd5);
        send_beat(ACT_ENQ, 16'd1, 1'b0, 64'd5);
        send_beat(ACT_ENQ, 16'd0, 1'b1, 64'd0);
        s_axis_tvalid <= 0;
        drain();
        write_cfg(CFG_TARGET, 60'hffff);
        write_cfg(CFG_LIMIT, 60'd0);
        send_beat(ACT_ENQ, 16'd1, 1'b0, '0);
        send_beat(ACT_TICK, 16'd0, 1'b0, '0);
        send_beat(ACT_TICK, 16'd0, 1'b0, '0);
        s_axis_tvalid <= 0;
        drain();
        write_cfg(CFG_UNUSED, 60'hfff);

        // random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph % 3;
            write_cfg(CFG_TARGET, 60'(ph == 7 ? 16'hffff : 16'($urandom_range(0, 60))));
            write_cfg(CFG_LIMIT, 60'(ph == 5 ? 16'hffff : 16'($urandom_range(0, 120))));
            write_cfg(CFG_ALPHA, ph == 6 ? 60'hfff_ffff_ffff_ffff :
                      60'({$urandom(), $urandom()}) % 60'd1000000000000000);
            write_cfg(CFG_BETA, ph == 6 ? 60'hfff_ffff_ffff_ffff :
                      60'({$urandom(), $urandom()}) % 60'd1000000000000000);
            write_cfg(CFG_ECN, 60'(ph[0]));
            write_cfg(CFG_BYTE, 60'(ph[1]));
            write_cfg(CFG_MTU, 60'(ph == 4 ? 16'hffff : 16'($urandom_range(0, 1600))));
            if (ph == 2) begin
                // long receiver hold-off while the sender keeps offering
                hold_off = 1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                    random_run(30, 60, 10);
                join
            end
            random_run(230, ph < 4 ? 60 : 45, 12);
            s_axis_tvalid <= 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("pi_aqm_drop_controller_unit regression: pass");
        else
            $display("pi_aqm_drop_controller_unit regression: fail");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+hdl
hdl/piaqm_pkg.sv
hdl/piaqm_dp.sv
hdl/piaqm_ctrl.sv
hdl/pi_aqm_drop_controller_unit.sv
hdl/piaqm_checker.sv
sim/tb.sv
